### rtl/sdiv_pkg.sv
// Package: payload and pipeline stage types for the signed integer divider.
`timescale 1ns / 1ps
`default_nettype none
package sdiv_pkg;

	localparam int W = 32;

	typedef struct packed {
		logic signed [W-1:0] numerator;
		logic signed [W-1:0] denominator;
	} sdiv_in_t;

	typedef struct packed {
		logic signed [W-1:0] quotient;
		logic                saturated;
		logic                divide_by_zero;
	} sdiv_out_t;

	typedef struct packed {
		logic         neg;
		logic         dz;
		logic [W-1:0] rem;
		logic [W-1:0] num;
		logic [W-1:0] den;
	} sdiv_stage_t;

endpackage
`default_nettype wire

### rtl/sdiv_setup.sv
// Setup stage: operand magnitudes, result sign and zero-divisor detect.
`timescale 1ns / 1ps
`default_nettype none
module sdiv_setup (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  valid_i,
	input  sdiv_pkg::sdiv_in_t   req_i,
	output logic                 valid_s1,
	output sdiv_pkg::sdiv_stage_t st_s1
);
	import sdiv_pkg::*;

	logic [W-1:0] n;
	logic [W-1:0] d;
	sdiv_stage_t  nxt;

	always_comb begin
		n       = req_i.numerator;
		d       = req_i.denominator;
		nxt.neg = n[W-1] ^ d[W-1];
		nxt.dz  = (d == '0);
		nxt.rem = '0;
		nxt.num = n[W-1] ? (~n + 1'b1) : n;
		nxt.den = d[W-1] ? (~d + 1'b1) : d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### rtl/sdiv_step.sv
// Divide stage: one restoring shift-and-subtract step, one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module sdiv_step (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   valid_i,
	input  sdiv_pkg::sdiv_stage_t st_i,
	output logic                  valid_s1,
	output sdiv_pkg::sdiv_stage_t st_s1
);
	import sdiv_pkg::*;

	logic [W-1:0] trial;
	logic         ge;
	sdiv_stage_t  nxt;

	always_comb begin
		trial   = {st_i.rem[W-2:0], st_i.num[W-1]};
		ge      = (trial >= st_i.den);
		nxt     = st_i;
		nxt.rem = ge ? (trial - st_i.den) : trial;
		nxt.num = {st_i.num[W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### rtl/sdiv_fix.sv
// Fix-up stage: sign restore, saturation and zero-divisor result, output register.
`timescale 1ns / 1ps
`default_nettype none
module sdiv_fix (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   valid_i,
	input  sdiv_pkg::sdiv_stage_t st_i,
	output logic                  valid_s1,
	output sdiv_pkg::sdiv_out_t   rsp_s1
);
	import sdiv_pkg::*;

	localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};

	sdiv_out_t nxt;

	always_comb begin
		nxt.quotient       = st_i.num;
		nxt.saturated      = 1'b0;
		nxt.divide_by_zero = 1'b0;
		if (st_i.dz) begin
			nxt.quotient       = '0;
			nxt.divide_by_zero = 1'b1;
		end else if (st_i.neg) begin
			nxt.quotient = ~st_i.num + 1'b1;
		end else if (st_i.num[W-1]) begin
			nxt.quotient  = MaxPos;
			nxt.saturated = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### rtl/signed_integer_divider_top.sv
// Top level: pipelined signed 32-bit divider, quotient truncated toward zero.
// Input channel req (req_valid/req_ready) carries numerator and denominator;
// output channel rsp (rsp_valid/rsp_ready) carries quotient, saturated and
// divide_by_zero. A beat moves when valid and ready are both high.
// The pipeline is one setup stage, 32 divide stages (one quotient bit each,
// one compare-subtract per stage) and one fix-up stage holding the output.
// rsp_valid rises once the req beat has passed the setup, divide and fix-up
// registers; a new beat is taken every cycle while the pipeline is not held,
// so throughput is one item per cycle.
// Zero divisor: quotient 0, divide_by_zero set. Most negative over -1:
// quotient 0x7FFFFFFF, saturated set.
// Reset clears all stage valid bits; the pipeline comes up empty.
// When rsp_valid is high and rsp_ready low, the whole pipeline holds and
// req_ready drops; no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_divider_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  sdiv_pkg::sdiv_in_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output sdiv_pkg::sdiv_out_t rsp
);
	import sdiv_pkg::*;

	logic        adv;
	logic        v_c  [0:W];
	sdiv_stage_t st_c [0:W];

	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	sdiv_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_i  (req_valid),
		.req_i    (req),
		.valid_s1 (v_c[0]),
		.st_s1    (st_c[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_step
		sdiv_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.valid_i  (v_c[i]),
			.st_i     (st_c[i]),
			.valid_s1 (v_c[i+1]),
			.st_s1    (st_c[i+1])
		);
	end

	sdiv_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid_i  (v_c[W]),
		.st_i     (st_c[W]),
		.valid_s1 (rsp_valid),
		.rsp_s1   (rsp)
	);

endmodule
`default_nettype wire

### test/sdiv_quotient_checker.sv
// Checker for the signed divider: predicts each quotient and compares response beats.
`timescale 1ns / 1ps
module sdiv_quotient_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire                 req_ready,
	input  sdiv_pkg::sdiv_in_t  req,
	input  wire                 rsp_valid,
	input  wire                 rsp_ready,
	input  sdiv_pkg::sdiv_out_t rsp,
	output int                  errors,
	output int                  outstanding
);
	import sdiv_pkg::*;

	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

	sdiv_out_t quotients_due[$];

	function automatic sdiv_out_t divide_truncated(sdiv_in_t beat);
		logic [W-1:0] num_mag;
		logic [W-1:0] den_mag;
		logic [W-1:0] mag_quot;
		logic         num_neg;
		logic         den_neg;
		sdiv_out_t    res;
		res = '0;
		num_neg = beat.numerator[W-1];
		den_neg = beat.denominator[W-1];
		num_mag = beat.numerator;
		den_mag = beat.denominator;
		if (num_neg) begin
			num_mag = -num_mag;
		end
		if (den_neg) begin
			den_mag = -den_mag;
		end
		if (den_mag == '0) begin
			res.divide_by_zero = 1'b1;
		end else begin
			mag_quot = num_mag / den_mag;
			if (num_neg != den_neg) begin
				res.quotient = -mag_quot;
			end else if (mag_quot[W-1]) begin
				res.quotient = MOST_POS;
				res.saturated = 1'b1;
			end else begin
				res.quotient = mag_quot;
			end
		end
		return res;
	endfunction

	initial begin
		errors = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		int        bad;
		sdiv_out_t due;
		bad = 0;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				quotients_due = {quotients_due, divide_truncated(req)};
			end
			if (rsp_valid && rsp_ready) begin
				if (quotients_due.size() == 0) begin
					$error("rsp beat with nothing pending: quotient %0d", rsp.quotient);
					bad++;
				end else begin
					due = quotients_due.pop_front();
					if (rsp.quotient !== due.quotient) begin
						$error("quotient: expected %0d, got %0d", due.quotient, rsp.quotient);
						bad++;
					end
					if (rsp.saturated !== due.saturated) begin
						$error("saturated: expected %0b, got %0b", due.saturated, rsp.saturated);
						bad++;
					end
					if (rsp.divide_by_zero !== due.divide_by_zero) begin
						$error("divide_by_zero: expected %0b, got %0b",
							due.divide_by_zero, rsp.divide_by_zero);
						bad++;
					end
				end
			end
		end
		errors <= errors + bad;
		outstanding <= quotients_due.size();
	end

endmodule

### test/tb_signed_integer_divider_top.sv
// Testbench top for the signed divider: request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module tb_signed_integer_divider_top;
	import sdiv_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam int CALM_ITEMS = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINUS_ONE = '1;
	localparam logic signed [W-1:0] ZERO = '0;
	localparam logic signed [W-1:0] ONE = 1;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	sdiv_in_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	sdiv_out_t rsp;
	int        stall_pct = 10;
	int        cycles = 0;
	int        errors;
	int        outstanding;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	signed_integer_divider_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sdiv_quotient_checker quotient_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_signed_integer_divider_top: done, errors");
			$finish;
		end
	end

	// response stalls in bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(99) < stall_pct) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	task automatic send_division(input logic signed [W-1:0] num, input logic signed [W-1:0] den);
		req <= '{numerator: num, denominator: den};
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if ($urandom_range(99) < stall_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic logic signed [W-1:0] pick_operand();
		logic signed [W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $urandom_range(0, 40);
			6: begin
				case ($urandom_range(4))
					0: v = ZERO;
					1: v = ONE;
					2: v = MINUS_ONE;
					3: v = MOST_NEG;
					default: v = MOST_POS;
				endcase
			end
			7: v = $urandom >> $urandom_range(0, W - 1);
			8: v = MOST_NEG + $urandom_range(0, 20);
			default: v = MOST_POS - $urandom_range(0, 20);
		endcase
		if ($urandom_range(1) == 1 && v != MOST_NEG && v != MOST_POS) begin
			v = -v;
		end
		return v;
	endfunction

	initial begin
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_division(7, 2);
		send_division(-7, 2);
		send_division(7, -2);
		send_division(-7, -2);
		send_division(MOST_NEG, MINUS_ONE);
		send_division(MOST_NEG, ONE);
		send_division(MOST_NEG, MOST_NEG);
		send_division(MOST_NEG, 2);
		send_division(MOST_NEG, MOST_POS);
		send_division(MOST_POS, MOST_NEG);
		send_division(MOST_POS, MOST_POS);
		send_division(MOST_POS, MINUS_ONE);
		send_division(MOST_POS, ONE);
		send_division(ONE, MOST_NEG);
		send_division(MINUS_ONE, MOST_NEG);
		send_division(ZERO, ZERO);
		send_division(MOST_NEG, ZERO);
		send_division(MOST_POS, ZERO);
		send_division(MINUS_ONE, ZERO);
		send_division(ZERO, MINUS_ONE);
		send_division(ZERO, MOST_NEG);
		send_division(MINUS_ONE, MINUS_ONE);
		send_division(5, 7);
		send_division(-5, 7);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 5;
					default: stall_pct = 25;
				endcase
			end
			if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
				stall_pct = 0;
			end
			num = pick_operand();
			den = pick_operand();
			case ($urandom_range(49))
				0: den = ZERO;
				1: begin
					num = MOST_NEG;
					den = MINUS_ONE;
				end
				default: ;
			endcase
			send_division(num, den);
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("tb_signed_integer_divider_top: done, clean");
		end else begin
			$display("tb_signed_integer_divider_top: done, errors");
		end
		$finish;
	end

endmodule
